### design/uvsph_pkg.sv
// Shared types, constants and helpers of the UV sphere vertex generator.
`timescale 1ns / 1ps
`default_nettype none
package uvsph_pkg;

    localparam int IDX_W   = 11;   // ring and segment indexes, counts
    localparam int Q_W     = 16;   // Q1.15 texture coordinate
    localparam int Z_W     = 15;   // quarter-wave argument 0..16384
    localparam int TRIG_W  = 16;   // signed Q1.14 sine and cosine
    localparam int POS_W   = 17;   // signed Q8.8 position
    localparam int RAD_W   = 16;   // unsigned Q8.8 radius

    localparam int MIN_SEGMENTS = 3;
    localparam int MIN_RINGS    = 2;

    localparam logic [Z_W-1:0] ONE_Q14 = 15'd16384;
    localparam logic [10:0] POLY_C1 = 11'd1160;
    localparam logic [13:0] POLY_C2 = 14'd10512;
    localparam logic [14:0] POLY_C3 = 15'd25736;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SEGMENTS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RINGS    = 2'd2;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 168;

    typedef logic signed [TRIG_W-1:0] t_trig;

    // Signed product scaled down by 2^14, rounded toward zero.
    function automatic logic signed [19:0] trunc_q14(input logic signed [33:0] p);
        logic signed [33:0] adj;
        adj = p + (p < 0 ? 34'sd16383 : 34'sd0);
        return 20'(adj >>> 14);
    endfunction

endpackage
`default_nettype wire

### design/uvsph_div.sv
// Pipelined restoring divider: quotient = (index * 2^15) / count, one bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module uvsph_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [uvsph_pkg::IDX_W-1:0]   i_num,
    input  wire logic [uvsph_pkg::IDX_W-1:0]   i_den,
    output logic      [uvsph_pkg::Q_W-1:0]     o_quo
);
    localparam int W = uvsph_pkg::IDX_W;
    localparam int N = uvsph_pkg::Q_W;

    logic [W-1:0] r_rem [0:N-2];
    logic [N-1:0] r_quo [0:N-1];

    // The integer bit of the quotient is 0 or 1 for indexes within the count.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= (i_num >= i_den) ? W'(i_num - i_den) : i_num;
            r_quo[0] <= {{(N-1){1'b0}}, (i_num >= i_den)};
        end
    end

    for (genvar k = 1; k < N; k++) begin : g_stage
        logic [W:0] w_sh;
        logic       w_ge;
        assign w_sh = {r_rem[k-1], 1'b0};
        assign w_ge = (w_sh >= {1'b0, i_den});
        if (k < N - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? W'(w_sh - {1'b0, i_den}) : w_sh[W-1:0];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {r_quo[k-1][N-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_quo[N-1];

endmodule
`default_nettype wire

### design/uvsph_qsine.sv
// Four-stage quarter-wave sine polynomial, Q14 in and out.
`timescale 1ns / 1ps
`default_nettype none
module uvsph_qsine (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [uvsph_pkg::Z_W-1:0]     i_z,
    output logic      [uvsph_pkg::TRIG_W-1:0]  o_s
);
    localparam int ZW = uvsph_pkg::Z_W;

    logic [ZW-1:0] r_z1, r_z2, r_z3;
    logic [ZW-1:0] r_sq1, r_sq2;
    logic [13:0]   r_t1;
    logic [14:0]   r_t2;
    logic [15:0]   r_s;

    logic [29:0] w_zz;
    logic [25:0] w_c1;
    logic [28:0] w_tz;
    logic [29:0] w_zt;

    assign w_zz = 30'(i_z * i_z);
    assign w_c1 = 26'(uvsph_pkg::POLY_C1 * r_sq1);
    assign w_tz = 29'(r_t1 * r_sq2);
    assign w_zt = 30'(r_z3 * r_t2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1  <= i_z;
            r_sq1 <= 15'(w_zz >> 14);
            r_z2  <= r_z1;
            r_sq2 <= r_sq1;
            r_t1  <= uvsph_pkg::POLY_C2 - 14'(w_c1 >> 14);
            r_z3  <= r_z2;
            r_t2  <= uvsph_pkg::POLY_C3 - 15'(w_tz >> 14);
            r_s   <= 16'(w_zt >> 14);
        end
    end

    assign o_s = r_s;

endmodule
`default_nettype wire

### design/uvsph_div_dummy_unused.sv
// Index range check of the UV sphere vertex generator.
`timescale 1ns / 1ps
`default_nettype none
module uvsph_range (
    input  wire logic [uvsph_pkg::IDX_W-1:0] i_ring,
    input  wire logic [uvsph_pkg::IDX_W-1:0] i_seg,
    input  wire logic [uvsph_pkg::IDX_W-1:0] i_rings,
    input  wire logic [uvsph_pkg::IDX_W-1:0] i_segs,
    output logic                              o_oor
);
    assign o_oor = (i_ring > i_rings) || (i_seg > i_segs);
endmodule
`default_nettype wire

### design/uv_sphere_vertex_generator.sv
// Top level of the UV sphere vertex generator.
`timescale 1ns / 1ps
`default_nettype none
// Takes one (ring, segment) word per cycle and returns one vertex word per
// cycle when not stalled, fully pipelined. Stages from input acceptance to the
// output register: one input stage, a 16-stage bit-per-stage divider for u
// and v, a 4-stage sine polynomial, then quadrant select, normal product and
// position product stages. The whole pipeline advances whenever the output
// register is empty or being taken, so back-pressure holds every stage.
// Configuration writes are always accepted and must only be made while the
// pipeline holds no items.
module uv_sphere_vertex_generator #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int MAX_RINGS    = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Input words: ring_index [10:0], segment_index [21:11].
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [uvsph_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // Output words: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tan_x,
    // tan_z, tex_u, tex_v from bit 0 upward.
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [uvsph_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
    // tuser: out_of_range.
    output logic                                       m_axis_tuser,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [uvsph_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire logic [15:0]                           i_cfg_data
);
    localparam int IW = uvsph_pkg::IDX_W;
    localparam int DL = uvsph_pkg::Q_W;
    localparam int SL = 4;

    logic [uvsph_pkg::RAD_W-1:0] r_radius;
    logic [IW-1:0] r_segcnt, r_ringcnt;
    logic [IW-1:0] w_segs, w_rings;
    logic w_adv, w_oor;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= 16'd256;
            r_segcnt  <= 11'd16;
            r_ringcnt <= 11'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                uvsph_pkg::REG_RADIUS:   r_radius  <= i_cfg_data;
                uvsph_pkg::REG_SEGMENTS: r_segcnt  <= i_cfg_data[IW-1:0];
                uvsph_pkg::REG_RINGS:    r_ringcnt <= i_cfg_data[IW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_segcnt < IW'(uvsph_pkg::MIN_SEGMENTS)) w_segs = IW'(uvsph_pkg::MIN_SEGMENTS);
        else if (32'(r_segcnt) > MAX_SEGMENTS)       w_segs = IW'(MAX_SEGMENTS);
        else                                         w_segs = r_segcnt;
        if (r_ringcnt < IW'(uvsph_pkg::MIN_RINGS))   w_rings = IW'(uvsph_pkg::MIN_RINGS);
        else if (32'(r_ringcnt) > MAX_RINGS)         w_rings = IW'(MAX_RINGS);
        else                                         w_rings = r_ringcnt;
    end

    logic r_out_valid;
    assign w_adv = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // Input stage.
    logic          r_a_valid, r_a_oor;
    logic [IW-1:0] r_a_ring, r_a_seg;

    uvsph_range u_range (
        .i_ring  (s_axis_tdata[10:0]),
        .i_seg   (s_axis_tdata[21:11]),
        .i_rings (w_rings),
        .i_segs  (w_segs),
        .o_oor   (w_oor)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= s_axis_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_ring <= s_axis_tdata[10:0];
            r_a_seg  <= s_axis_tdata[21:11];
            r_a_oor  <= w_oor;
        end
    end

    // Divider stages.
    logic [uvsph_pkg::Q_W-1:0] w_u, w_v;

    uvsph_div u_div_u (.i_clk(i_clk), .i_en(w_adv), .i_num(r_a_seg),
                       .i_den(w_segs), .o_quo(w_u));
    uvsph_div u_div_v (.i_clk(i_clk), .i_en(w_adv), .i_num(r_a_ring),
                       .i_den(w_rings), .o_quo(w_v));

    logic r_dl_valid [0:DL-1];
    logic r_dl_oor   [0:DL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DL; k++) r_dl_valid[k] <= 1'b0;
        end else if (w_adv) begin
            r_dl_valid[0] <= r_a_valid;
            for (int k = 1; k < DL; k++) r_dl_valid[k] <= r_dl_valid[k-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dl_oor[0] <= r_a_oor;
            for (int k = 1; k < DL; k++) r_dl_oor[k] <= r_dl_oor[k-1];
        end
    end

    // Angles in 1/65536 turn: theta = v, phi = 2u.
    logic [15:0] w_theta, w_phi;
    assign w_theta = w_v;
    assign w_phi   = {w_u[14:0], 1'b0};

    logic [uvsph_pkg::Z_W-1:0] w_zt_s, w_zt_c, w_zp_s, w_zp_c;
    assign w_zt_s = {1'b0, w_theta[13:0]};
    assign w_zt_c = uvsph_pkg::ONE_Q14 - {1'b0, w_theta[13:0]};
    assign w_zp_s = {1'b0, w_phi[13:0]};
    assign w_zp_c = uvsph_pkg::ONE_Q14 - {1'b0, w_phi[13:0]};

    logic [15:0] w_st_x, w_st_c, w_sp_x, w_sp_c;

    uvsph_qsine u_qs_t0 (.i_clk(i_clk), .i_en(w_adv), .i_z(w_zt_s), .o_s(w_st_x));
    uvsph_qsine u_qs_t1 (.i_clk(i_clk), .i_en(w_adv), .i_z(w_zt_c), .o_s(w_st_c));
    uvsph_qsine u_qs_p0 (.i_clk(i_clk), .i_en(w_adv), .i_z(w_zp_s), .o_s(w_sp_x));
    uvsph_qsine u_qs_p1 (.i_clk(i_clk), .i_en(w_adv), .i_z(w_zp_c), .o_s(w_sp_c));

    logic        r_sl_valid [0:SL-1];
    logic        r_sl_oor   [0:SL-1];
    logic [15:0] r_sl_u     [0:SL-1];
    logic [15:0] r_sl_v     [0:SL-1];
    logic [1:0]  r_sl_qt    [0:SL-1];
    logic [1:0]  r_sl_qp    [0:SL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SL; k++) r_sl_valid[k] <= 1'b0;
        end else if (w_adv) begin
            r_sl_valid[0] <= r_dl_valid[DL-1];
            for (int k = 1; k < SL; k++) r_sl_valid[k] <= r_sl_valid[k-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sl_oor[0] <= r_dl_oor[DL-1];
            r_sl_u[0]   <= w_u;
            r_sl_v[0]   <= w_v;
            r_sl_qt[0]  <= w_theta[15:14];
            r_sl_qp[0]  <= w_phi[15:14];
            for (int k = 1; k < SL; k++) begin
                r_sl_oor[k] <= r_sl_oor[k-1];
                r_sl_u[k]   <= r_sl_u[k-1];
                r_sl_v[k]   <= r_sl_v[k-1];
                r_sl_qt[k]  <= r_sl_qt[k-1];
                r_sl_qp[k]  <= r_sl_qp[k-1];
            end
        end
    end

    // Quadrant select.
    uvsph_pkg::t_trig n_st, n_ct, n_sp, n_cp;
    always_comb begin
        case (r_sl_qt[SL-1])
            2'd0:    begin n_st =  w_st_x; n_ct =  w_st_c; end
            2'd1:    begin n_st =  w_st_c; n_ct = -w_st_x; end
            2'd2:    begin n_st = -w_st_x; n_ct = -w_st_c; end
            default: begin n_st = -w_st_c; n_ct =  w_st_x; end
        endcase
        case (r_sl_qp[SL-1])
            2'd0:    begin n_sp =  w_sp_x; n_cp =  w_sp_c; end
            2'd1:    begin n_sp =  w_sp_c; n_cp = -w_sp_x; end
            2'd2:    begin n_sp = -w_sp_x; n_cp = -w_sp_c; end
            default: begin n_sp = -w_sp_c; n_cp =  w_sp_x; end
        endcase
    end

    logic r_b_valid, r_b_oor;
    logic [15:0] r_b_u, r_b_v;
    uvsph_pkg::t_trig r_b_st, r_b_ct, r_b_sp, r_b_cp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= r_sl_valid[SL-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_oor <= r_sl_oor[SL-1];
            r_b_u   <= r_sl_u[SL-1];
            r_b_v   <= r_sl_v[SL-1];
            r_b_st  <= n_st;
            r_b_ct  <= n_ct;
            r_b_sp  <= n_sp;
            r_b_cp  <= n_cp;
        end
    end

    // Normal products.
    logic signed [33:0] w_px, w_pz;
    assign w_px = 34'(r_b_st * r_b_cp);
    assign w_pz = 34'(r_b_st * r_b_sp);

    logic r_c_valid, r_c_oor;
    logic [15:0] r_c_u, r_c_v;
    uvsph_pkg::t_trig r_c_nx, r_c_ny, r_c_nz, r_c_tx, r_c_tz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_adv) begin
            r_c_valid <= r_b_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_oor <= r_b_oor;
            r_c_u   <= r_b_u;
            r_c_v   <= r_b_v;
            r_c_nx  <= 16'(uvsph_pkg::trunc_q14(w_px));
            r_c_ny  <= r_b_ct;
            r_c_nz  <= 16'(uvsph_pkg::trunc_q14(w_pz));
            r_c_tx  <= -r_b_sp;
            r_c_tz  <= r_b_cp;
        end
    end

    // Position products and output register.
    logic signed [16:0] w_rad;
    logic signed [33:0] w_qx, w_qy, w_qz;
    assign w_rad = signed'({1'b0, r_radius});
    assign w_qx  = 34'(r_c_nx * w_rad);
    assign w_qy  = 34'(r_c_ny * w_rad);
    assign w_qz  = 34'(r_c_nz * w_rad);

    logic [uvsph_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                             r_out_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_c_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_oor <= r_c_oor;
            if (r_c_oor) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {5'd0, r_c_v, r_c_u, r_c_tz, r_c_tx, r_c_nz, r_c_ny, r_c_nx,
                               17'(uvsph_pkg::trunc_q14(w_qz)),
                               17'(uvsph_pkg::trunc_q14(w_qy)),
                               17'(uvsph_pkg::trunc_q14(w_qx))};
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_oor;

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("out-of-range vertex carries nonzero data");

    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
        (m_axis_tdata[146:131] <= 16'd32768 && m_axis_tdata[162:147] <= 16'd32768))
        else $error("texture coordinate above one");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stage");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

endmodule
`default_nettype wire
